FILE: hdl/rde_pkg.sv
// Shared constants and types for the reversible deque engine.
`timescale 1ns / 1ps

package rde_pkg;

   // Default geometry of the element store
   localparam int RDE_DEPTH      = 1024;
   localparam int RDE_ELEM_WIDTH = 8;

   // Command codes carried on the request tuser
   localparam int FUNC_WIDTH = 3;
   typedef logic [FUNC_WIDTH-1:0] func_type;

   localparam func_type FUNC_PUSH    = 3'd0;
   localparam func_type FUNC_REVERSE = 3'd1;
   localparam func_type FUNC_DELETE  = 3'd2;
   localparam func_type FUNC_READ    = 3'd3;
   localparam func_type FUNC_CLEAR   = 3'd4;

endpackage

FILE: hdl/reversible_deque_engine.sv
// Ring-buffer deque with constant-time reverse: pointer logic, element store, result stages.
`timescale 1ns / 1ps

// Reversible deque engine. Each request beat carries one command (push, reverse, delete
// front, read front, clear) and yields exactly one response beat with the popped value,
// the count left, and the error, empty-read, last and overflow flags. One command is
// taken every cycle while the response side keeps up; each response passes through the
// pending stage and the response register before rsp_tvalid rises. The rate is set by
// the single-port element store, which sees
// one access per command (a write for push, a read for read), and by the head/count
// registers, which are updated at the request beat so the next command sees them at
// once. A delete on an empty deque sets a sticky error that blocks everything but clear.
// The store needs no clearing after reset: only entries written by a push are ever read.
module reversible_deque_engine #(
   parameter  int DEPTH      = rde_pkg::RDE_DEPTH,
   parameter  int ELEM_WIDTH = rde_pkg::RDE_ELEM_WIDTH,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int REQ_DW     = ((ELEM_WIDTH + 7) / 8) * 8,
   localparam int RSP_DW     = ((ELEM_WIDTH + CW + 3 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,  // value
   input  rde_pkg::func_type req_tuser,  // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,  // read_value, remaining, error_flag, empty_read,
                                         // overflow
   output logic              rsp_tlast   // is_last
);
   import rde_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam int PAD_W = RSP_DW - (ELEM_WIDTH + CW + 3);

   // Deque state
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rev_ff, rev_in;
   logic          err_ff, err_in;

   // Element store
   logic [ELEM_WIDTH-1:0] store_mem [DEPTH];
   logic [ELEM_WIDTH-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_addr;

   // Stage between the store read and the response register
   logic          pend_ff, pend_in;
   logic          pend_rd_ff, pend_rd_in;
   logic [CW-1:0] pend_cnt_ff, pend_cnt_in;
   logic          pend_err_ff, pend_err_in;
   logic          pend_empty_ff, pend_empty_in;
   logic          pend_last_ff, pend_last_in;
   logic          pend_ovf_ff, pend_ovf_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                  accept, advance;
   func_type              func;
   logic [ELEM_WIDTH-1:0] value;
   logic [AW:0]           sum_tail, sum_back;
   logic [AW-1:0]         tail_slot, back_slot, head_inc, head_dec;
   logic                  is_empty, is_full;

   assign func     = req_tuser;
   assign value    = req_tdata[ELEM_WIDTH-1:0];
   assign advance  = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || advance;
   assign accept   = req_tvalid && req_tready;
   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff >= DEPTH_C);

   // Slot arithmetic modulo DEPTH: sums stay below twice DEPTH
   always_comb begin
      sum_tail  = {1'b0, head_ff} + (AW + 1)'(cnt_ff);
      sum_back  = sum_tail - (AW + 1)'(1);
      tail_slot = (sum_tail >= DEPTH_W) ? AW'(sum_tail - DEPTH_W) : sum_tail[AW-1:0];
      back_slot = (sum_back >= DEPTH_W) ? AW'(sum_back - DEPTH_W) : sum_back[AW-1:0];
      head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
      head_dec  = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   end

   // Execute the command at the request beat
   always_comb begin
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      rev_in        = rev_ff;
      err_in        = err_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = head_ff;
      pend_rd_in    = 1'b0;
      pend_empty_in = 1'b0;
      pend_last_in  = 1'b0;
      pend_ovf_in   = 1'b0;
      if (accept) begin
         if (func == FUNC_CLEAR) begin
            head_in = '0;
            cnt_in  = '0;
            rev_in  = 1'b0;
            err_in  = 1'b0;
         end else if (!err_ff) begin
            case (func)
               FUNC_PUSH: begin
                  if (is_full) begin
                     pend_ovf_in = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                     if (rev_ff) begin
                        head_in  = head_dec;
                        mem_addr = head_dec;
                     end else begin
                        mem_addr = tail_slot;
                     end
                  end
               end
               FUNC_REVERSE: begin
                  rev_in = !rev_ff;
               end
               FUNC_DELETE: begin
                  if (is_empty) begin
                     err_in = 1'b1;
                  end else begin
                     cnt_in = cnt_ff - CW'(1);
                     if (!rev_ff) head_in = head_inc;
                  end
               end
               FUNC_READ: begin
                  if (is_empty) begin
                     pend_empty_in = 1'b1;
                  end else begin
                     mem_re       = 1'b1;
                     pend_rd_in   = 1'b1;
                     cnt_in       = cnt_ff - CW'(1);
                     pend_last_in = (cnt_ff == CW'(1));
                     if (rev_ff) begin
                        mem_addr = back_slot;
                     end else begin
                        mem_addr = head_ff;
                        head_in  = head_inc;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
      pend_cnt_in = cnt_in;
      pend_err_in = err_in;
   end

   // Hold the deque state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
         rev_ff  <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
         rev_ff  <= rev_in;
         err_ff  <= err_in;
      end
   end

   // Element store: one access per command, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_addr] <= value;
      if (mem_re) rd_data_ff <= store_mem[mem_addr];
   end

   // Pending stage: waits for the store read data
   always_comb begin
      pend_in = accept || (pend_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else       pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_rd_ff    <= pend_rd_in;
         pend_cnt_ff   <= pend_cnt_in;
         pend_err_ff   <= pend_err_in;
         pend_empty_ff <= pend_empty_in;
         pend_last_ff  <= pend_last_in;
         pend_ovf_ff   <= pend_ovf_in;
      end
   end

   // Response register: load on advance, drop on the taken beat
   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = {{PAD_W{1'b0}}, pend_ovf_ff, pend_empty_ff, pend_err_ff, pend_cnt_ff,
                      (pend_rd_ff ? rd_data_ff : {ELEM_WIDTH{1'b0}})};
      rsp_last_in  = pend_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/rde_checker.sv
// Port-level checks for the reversible deque engine, bound to the top level.
`timescale 1ns / 1ps

module rde_checker #(
   parameter  int DEPTH      = rde_pkg::RDE_DEPTH,
   parameter  int ELEM_WIDTH = rde_pkg::RDE_ELEM_WIDTH,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int RSP_DW     = ((ELEM_WIDTH + CW + 3 + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,  // read_value, remaining, error_flag, empty_read,
                                        // overflow
   input logic              rsp_tlast   // is_last
);

   localparam int CNT_LSB   = ELEM_WIDTH;
   localparam int EMPTY_BIT = ELEM_WIDTH + CW + 1;
   localparam int OVF_BIT   = ELEM_WIDTH + CW + 2;

   logic [CW-1:0] remaining;

   assign remaining = rsp_tdata[CNT_LSB +: CW];

   // A response holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // The final element leaves an empty deque
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> remaining == '0)
      else $error("last element reported with elements left");

   // A read with nothing to return comes only from an empty deque
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[EMPTY_BIT] |-> remaining == '0 && !rsp_tlast)
      else $error("empty read reported with elements held");

   // A refused push only happens on a full store
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OVF_BIT] |-> remaining == CW'(DEPTH))
      else $error("overflow reported below full");

   // No response beat rises without a command accepted ahead of it through the pending stage
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response beat without a command");

endmodule

bind reversible_deque_engine rde_checker #(
   .DEPTH      (DEPTH),
   .ELEM_WIDTH (ELEM_WIDTH)
) u_rde_checker (.*);
